// ----- rtl/core/rmq_pkg.sv -----
// Shared types and widths for the rotation-matrix-to-quaternion pipeline.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package rmq_pkg;

  localparam int unsigned DATA_W        = 32;  // matrix entries and quaternion fields
  localparam int unsigned P_W           = 35;  // signed vector before normalisation
  localparam int unsigned MAG_W         = 34;  // magnitude of that vector
  localparam int unsigned LEN_W         = 6;   // bit length of the largest magnitude
  localparam int unsigned MG_W          = 31;  // normalised magnitude
  localparam int unsigned SQ_W          = 2 * MG_W;
  localparam int unsigned N2_W          = 64;  // sum of squares
  localparam int unsigned ROOT_W        = 32;  // integer square root of that sum
  localparam int unsigned SQRT_STEPS    = N2_W / 2;
  localparam int unsigned QUO_W         = 32;  // quotient bits, one per divide stage
  localparam int unsigned NUM_W         = 62;  // dividend width at the widest fraction
  localparam int unsigned FRAC_BITS_DEF = 30;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] qx;
    logic signed [DATA_W-1:0] qy;
    logic signed [DATA_W-1:0] qz;
    logic signed [DATA_W-1:0] qw;
    logic                     status;
  } rsp_t;

  // Per-item sideband that rides alongside the square-root stages.
  typedef struct packed {
    logic [3:0]            neg;
    logic                  bad;
    logic [3:0][MG_W-1:0]  mg;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/rmq_front.sv -----
// Front end: branch selection, vector forming, magnitude normalisation, sum of squares.
// Depends on rmq_pkg.
`default_nettype none

module rmq_front
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire req_t               req_i,
  output logic                    valid_o,
  output logic [N2_W-1:0]         n2_o,
  output side_t                   side_o
);

  localparam int unsigned STAGES = 7;
  localparam logic signed [P_W-1:0] ONE = P_W'(1) <<< FRAC_BITS;

  logic [STAGES-1:0] v_q;

  // stage 1: signed vector
  logic signed [P_W-1:0] m [3][3];
  logic signed [P_W-1:0] trace, rad;
  logic signed [P_W-1:0] p_d [4];
  axis_e ia, ib, ic;
  logic signed [P_W-1:0] p_q [4];
  logic [3:0] bad_q;

  // later stages
  logic [MAG_W-1:0] mag2_q [4], mag3_q [4], mag4_q [4];
  logic [3:0]       neg2_q, neg3_q, neg4_q, neg5_q, neg6_q, neg7_q;
  logic [MAG_W-1:0] mx_d, mx_q;
  logic [LEN_W-1:0] len_d, len_q;
  logic [MG_W-1:0]  mg5_q [4], mg6_q [4], mg7_q [4];
  logic [SQ_W-1:0]  sq_q [4];
  logic [N2_W-1:0]  n2_q;
  logic [MAG_W+MG_W-1:0] sh_tmp [4];

  always_comb begin
    m[0][0] = P_W'(req_i.m00); m[0][1] = P_W'(req_i.m01); m[0][2] = P_W'(req_i.m02);
    m[1][0] = P_W'(req_i.m10); m[1][1] = P_W'(req_i.m11); m[1][2] = P_W'(req_i.m12);
    m[2][0] = P_W'(req_i.m20); m[2][1] = P_W'(req_i.m21); m[2][2] = P_W'(req_i.m22);
    trace = m[0][0] + m[1][1] + m[2][2];
    if (req_i.m00 < req_i.m11) begin
      ia = (req_i.m11 < req_i.m22) ? AXIS_Z : AXIS_Y;
    end else begin
      ia = (req_i.m00 < req_i.m22) ? AXIS_Z : AXIS_X;
    end
    case (ia)
      AXIS_X:  begin ib = AXIS_Y; ic = AXIS_Z; end
      AXIS_Y:  begin ib = AXIS_Z; ic = AXIS_X; end
      AXIS_Z:  begin ib = AXIS_X; ic = AXIS_Y; end
      default: begin ib = AXIS_Y; ic = AXIS_Z; end
    endcase
    for (int i = 0; i < 4; i++) p_d[i] = '0;
    if (trace > 0) begin
      rad    = trace + ONE;
      p_d[3] = rad;
      p_d[0] = m[2][1] - m[1][2];
      p_d[1] = m[0][2] - m[2][0];
      p_d[2] = m[1][0] - m[0][1];
    end else begin
      rad     = ONE + m[ia][ia] - m[ib][ib] - m[ic][ic];
      p_d[ia] = rad;
      p_d[3]  = m[ic][ib] - m[ib][ic];
      p_d[ib] = m[ia][ib] + m[ib][ia];
      p_d[ic] = m[ic][ia] + m[ia][ic];
    end
  end

  // largest magnitude, then its bit length
  always_comb begin
    logic [MAG_W-1:0] a, b;
    a    = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
    b    = (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];
    mx_d = (a > b) ? a : b;
    len_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx_q[i]) len_d = LEN_W'(i + 1);
    end
    for (int i = 0; i < 4; i++) begin
      sh_tmp[i] = {mag4_q[i], {MG_W{1'b0}}} >> len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad_q  <= {bad_q[2:0], (rad <= 0)};
      neg3_q <= neg2_q;
      neg4_q <= neg3_q;
      neg5_q <= neg4_q;
      neg6_q <= neg5_q;
      neg7_q <= neg6_q;
      mx_q   <= mx_d;
      len_q  <= len_d;
      n2_q   <= N2_W'(sq_q[0]) + N2_W'(sq_q[1]) + N2_W'(sq_q[2]) + N2_W'(sq_q[3]);
      for (int i = 0; i < 4; i++) begin
        p_q[i]    <= p_d[i];
        neg2_q[i] <= p_q[i][P_W-1];
        mag2_q[i] <= MAG_W'(p_q[i][P_W-1] ? -p_q[i] : p_q[i]);
        mag3_q[i] <= mag2_q[i];
        mag4_q[i] <= mag3_q[i];
        mg5_q[i]  <= sh_tmp[i][MG_W-1:0];
        sq_q[i]   <= mg5_q[i] * mg5_q[i];
        mg6_q[i]  <= mg5_q[i];
        mg7_q[i]  <= mg6_q[i];
      end
    end
  end

  // bad_q[3] lines up with stage 4; bad5_q to bad7_q carry it on to the sum
  logic bad6_q, bad7_q, bad5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad5_q <= bad_q[3];
      bad6_q <= bad5_q;
      bad7_q <= bad6_q;
    end
  end

  assign valid_o     = v_q[STAGES-1];
  assign n2_o        = n2_q;
  assign side_o.neg  = neg7_q;
  assign side_o.bad  = bad7_q;
  assign side_o.mg   = {mg7_q[3], mg7_q[2], mg7_q[1], mg7_q[0]};

endmodule

`default_nettype wire

// ----- rtl/core/rmq_sqrt.sv -----
// Integer square root, one result bit per pipeline stage.
// Depends on rmq_pkg.
`default_nettype none

module rmq_sqrt
  import rmq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [N2_W-1:0]   n2_i,
  input  wire side_t             side_i,
  output logic                   valid_o,
  output logic [ROOT_W-1:0]      root_o,
  output side_t                  side_o
);

  logic [N2_W-1:0] rem_q  [SQRT_STEPS];
  logic [N2_W-1:0] res_q  [SQRT_STEPS];
  side_t           side_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] v_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [N2_W-1:0] BIT = N2_W'(1) << (N2_W - 2 - 2 * k);
    logic [N2_W-1:0] rem_p, res_p, tst;
    logic            ge;
    side_t           side_p;

    if (k == 0) begin : g_first
      assign rem_p  = n2_i;
      assign res_p  = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign res_p  = res_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign tst = res_p + BIT;
    assign ge  = (rem_p >= tst);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_p - tst : rem_p;
        res_q[k]  <= ge ? (res_p >> 1) + BIT : res_p >> 1;
        side_q[k] <= side_p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[SQRT_STEPS-2:0], valid_i};
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign root_o  = res_q[SQRT_STEPS-1][ROOT_W-1:0];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/rmq_div.sv -----
// Four-lane restoring divider: rounded magnitude over the norm, one bit per stage.
// Depends on rmq_pkg.
`default_nettype none

module rmq_div
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [ROOT_W-1:0]        root_i,
  input  wire side_t                    side_i,
  output logic                          valid_o,
  output logic [3:0][QUO_W-1:0]         quo_o,
  output logic [3:0]                    neg_o,
  output logic                          bad_o
);

  localparam int unsigned STAGES = QUO_W + 1;

  logic [STAGES-1:0] v_q;
  logic [ROOT_W-1:0] den_q [STAGES];
  logic [3:0]        neg_q [STAGES];
  logic              bad_q [STAGES];
  logic [QUO_W-1:0]  rem_q [STAGES][4];
  logic [QUO_W-1:0]  lo_q  [STAGES][4];

  // prepare dividend: magnitude scaled up plus half the norm for rounding
  always_ff @(posedge clk_i) begin
    logic [NUM_W-1:0] num;
    if (en_i) begin
      den_q[0] <= root_i;
      neg_q[0] <= side_i.neg;
      bad_q[0] <= side_i.bad;
      for (int i = 0; i < 4; i++) begin
        num         = (NUM_W'(side_i.mg[i]) << FRAC_BITS) + NUM_W'(root_i >> 1);
        rem_q[0][i] <= QUO_W'(num[NUM_W-1:QUO_W]);
        lo_q[0][i]  <= num[QUO_W-1:0];
      end
    end
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      logic [QUO_W:0] t;
      logic           ge;
      if (en_i) begin
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        bad_q[k] <= bad_q[k-1];
        for (int i = 0; i < 4; i++) begin
          t  = {rem_q[k-1][i], lo_q[k-1][i][QUO_W-1]};
          ge = (t >= {1'b0, den_q[k-1]});
          rem_q[k][i] <= ge ? QUO_W'(t - {1'b0, den_q[k-1]}) : t[QUO_W-1:0];
          lo_q[k][i]  <= {lo_q[k-1][i][QUO_W-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign quo_o   = {lo_q[STAGES-1][3], lo_q[STAGES-1][2], lo_q[STAGES-1][1],
                    lo_q[STAGES-1][0]};
  assign neg_o   = neg_q[STAGES-1];
  assign bad_o   = bad_q[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/rotation_matrix_to_quaternion.sv -----
// Top level: rotation matrix (Q2.30) in, unit quaternion out, fully pipelined.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------------
//  input   | in_valid_i | in_ready_o  | in_req_i   (nine matrix entries)
//  output  | out_valid_o| out_ready_i | out_rsp_o  (qx qy qz qw status)
//
// One request enters per cycle while in_ready_o is high. There are 73 register
// stages: 7 front-end stages, 32 square-root stages (one root bit each), 33
// divider stages (dividend set-up plus one quotient bit each) and the output
// register. Reset clears only the valid bits. The whole pipe, bubbles included,
// holds only when the output register is full, not taken, and the last divider
// stage holds a request; while that stage is a bubble the pipe keeps advancing.
`default_nettype none

module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  logic              load, en;
  logic              fe_valid, sq_valid, dv_valid;
  logic [N2_W-1:0]   n2;
  side_t             fe_side, sq_side;
  logic [ROOT_W-1:0] root;
  logic [3:0][QUO_W-1:0] quo;
  logic [3:0]        neg;
  logic              bad;
  logic              out_valid_q;
  rsp_t              rsp_q, rsp_d;
  logic [DATA_W-1:0] q_fix [4];

  // Take a new result when the output is empty or being drained; advance the
  // pipe too whenever its last stage is a bubble.
  assign load       = out_ready_i || !out_valid_q;
  assign en         = load || !dv_valid;
  assign in_ready_o = en;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (fe_valid),
    .n2_o    (n2),
    .side_o  (fe_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .n2_i    (n2),
    .side_i  (fe_side),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (root),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .neg_o   (neg),
    .bad_o   (bad)
  );

  // Put the signs back; a non-positive radicand forces all components to zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_fix[i] = bad ? '0 : (neg[i] ? DATA_W'(-quo[i]) : DATA_W'(quo[i]));
    end
    rsp_d.qx     = q_fix[0];
    rsp_d.qy     = q_fix[1];
    rsp_d.qz     = q_fix[2];
    rsp_d.qw     = q_fix[3];
    rsp_d.status = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && dv_valid) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTH
  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) <<< FRAC_BITS;

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status |->
      out_rsp_o.qx == '0 && out_rsp_o.qy == '0 && out_rsp_o.qz == '0 && out_rsp_o.qw == '0)
    else $error("status set with nonzero quaternion");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.status |->
      out_rsp_o.qx <= ONE_Q && out_rsp_o.qx >= -ONE_Q &&
      out_rsp_o.qw <= ONE_Q && out_rsp_o.qw >= -ONE_Q)
    else $error("quaternion component beyond one");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && dv_valid |-> !in_ready_o)
    else $error("pipe advanced while output blocked");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid && !load |=> dv_valid)
    else $error("stalled result lost");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for rotation_matrix_to_quaternion: matrix requests in, quaternions out.
// Holds its own fixed-point predictor and a scoreboard; depends on rmq_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;
  import rmq_pkg::*;

  localparam int unsigned FB        = FRAC_BITS_DEF;
  localparam longint      ONE_FX    = longint'(1) << FB;
  localparam int unsigned LATENCY   = 73;
  localparam longint      CYCLE_CAP = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  rsp_t   quat_expected[$];
  int     error_count = 0;
  int     checked_count = 0;
  int     sent_count = 0;
  int     bad_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_off_cycles = 0;
  longint cycle_count = 0;

  always #10 clk_i = ~clk_i;

  rotation_matrix_to_quaternion i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Bit-exact integer square root, one result bit per step.
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Predict the quaternion for one matrix request.
  function automatic rsp_t quat_of_matrix(req_t r);
    longint          m[3][3];
    longint          p[4];
    longint          rad, tr;
    longint unsigned mg[4];
    longint unsigned mx, n2, nrm, q;
    int              len, a, b, c;
    rsp_t            o;
    m[0][0] = longint'(r.m00); m[0][1] = longint'(r.m01); m[0][2] = longint'(r.m02);
    m[1][0] = longint'(r.m10); m[1][1] = longint'(r.m11); m[1][2] = longint'(r.m12);
    m[2][0] = longint'(r.m20); m[2][1] = longint'(r.m21); m[2][2] = longint'(r.m22);
    o = '0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      rad = tr + ONE_FX;
      p[3] = rad;
      p[0] = m[2][1] - m[1][2];
      p[1] = m[0][2] - m[2][0];
      p[2] = m[1][0] - m[0][1];
    end else begin
      // Largest diagonal entry picks the axis; ties fall as the comparison chain dictates.
      if (m[0][0] < m[1][1]) a = (m[1][1] < m[2][2]) ? int'(AXIS_Z) : int'(AXIS_Y);
      else a = (m[0][0] < m[2][2]) ? int'(AXIS_Z) : int'(AXIS_X);
      b = (a + 1) % 3;
      c = (a + 2) % 3;
      rad = ONE_FX + m[a][a] - m[b][b] - m[c][c];
      p[a] = rad;
      p[3] = m[c][b] - m[b][c];
      p[b] = m[a][b] + m[b][a];
      p[c] = m[c][a] + m[a][c];
    end
    if (rad <= 0) begin
      o.status = 1'b1;
      return o;
    end
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      mg[i] = (p[i] < 0) ? longint'(-p[i]) : p[i];
      if (mg[i] > mx) mx = mg[i];
    end
    len = 0;
    while (len < 64 && (mx >> len) != 0) len++;
    n2 = 0;
    for (int i = 0; i < 4; i++) begin
      if (len > 31) mg[i] >>= (len - 31);
      else mg[i] <<= (31 - len);
      n2 += mg[i] * mg[i];
    end
    nrm = root64(n2);
    for (int i = 0; i < 4; i++) begin
      q = ((mg[i] << FB) + (nrm >> 1)) / nrm;
      if (p[i] < 0) q = 64'd0 - q;
      case (i)
        0: o.qx = q[31:0];
        1: o.qy = q[31:0];
        2: o.qz = q[31:0];
        default: o.qw = q[31:0];
      endcase
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("MISMATCH %s at result %0d: got %h want %h", what, checked_count, got, want);
  endtask

  // Offer one request and hold it until taken; drop valid only while idling.
  task automatic send_matrix(req_t r);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    quat_expected.push_back(quat_of_matrix(r));
    sent_count++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drain: drop valid, wait for every expected result, then let the pipe settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (recv_idle_pct == 0) || ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Scoreboard: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quat_expected.size() == 0) begin
        error_count++;
        $display("UNEXPECTED result %h", out_rsp_o);
      end else begin
        want = quat_expected.pop_front();
        if (out_rsp_o.qx !== want.qx) report_mismatch("qx", out_rsp_o.qx, want.qx);
        if (out_rsp_o.qy !== want.qy) report_mismatch("qy", out_rsp_o.qy, want.qy);
        if (out_rsp_o.qz !== want.qz) report_mismatch("qz", out_rsp_o.qz, want.qz);
        if (out_rsp_o.qw !== want.qw) report_mismatch("qw", out_rsp_o.qw, want.qw);
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", 32'(out_rsp_o.status), 32'(want.status));
        if (want.status) bad_count++;
      end
      checked_count++;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(5, 0))
      0: return $urandom();                              // any pattern
      1: return -32'sd1073741824;
      2: return 32'sd1073741824;
      default: return $urandom_range(32'd2147483647, 0) - 32'sd1073741824;
    endcase
  endfunction

  // Build a near-rotation from a random unit quaternion, in Q2.30.
  function automatic req_t rotation_from_angles();
    real  qa, qb, qc, qd, s;
    req_t r;
    qa = $urandom_range(2000, 0) / 1000.0 - 1.0;
    qb = $urandom_range(2000, 0) / 1000.0 - 1.0;
    qc = $urandom_range(2000, 0) / 1000.0 - 1.0;
    qd = $urandom_range(2000, 0) / 1000.0 - 1.0;
    s = $sqrt(qa*qa + qb*qb + qc*qc + qd*qd);
    if (s < 1e-3) begin qd = 1.0; s = 1.0; end
    qa /= s; qb /= s; qc /= s; qd /= s;
    r.m00 = $rtoi((1 - 2*(qb*qb + qc*qc)) * ONE_FX);
    r.m01 = $rtoi(2*(qa*qb - qc*qd) * ONE_FX);
    r.m02 = $rtoi(2*(qa*qc + qb*qd) * ONE_FX);
    r.m10 = $rtoi(2*(qa*qb + qc*qd) * ONE_FX);
    r.m11 = $rtoi((1 - 2*(qa*qa + qc*qc)) * ONE_FX);
    r.m12 = $rtoi(2*(qb*qc - qa*qd) * ONE_FX);
    r.m20 = $rtoi(2*(qa*qc - qb*qd) * ONE_FX);
    r.m21 = $rtoi(2*(qb*qc + qa*qd) * ONE_FX);
    r.m22 = $rtoi((1 - 2*(qa*qa + qb*qb)) * ONE_FX);
    return r;
  endfunction

  function automatic req_t diag_matrix(longint d0, longint d1, longint d2);
    req_t r;
    r = '0;
    r.m00 = 32'(d0); r.m11 = 32'(d1); r.m22 = 32'(d2);
    return r;
  endfunction

  // Extremes, each branch and ties on the diagonal.
  task automatic test_directed();
    req_t r;
    send_matrix(diag_matrix(ONE_FX, ONE_FX, ONE_FX));       // identity, trace branch
    send_matrix(diag_matrix(ONE_FX, -ONE_FX, -ONE_FX));     // half-turn about x
    send_matrix(diag_matrix(-ONE_FX, ONE_FX, -ONE_FX));     // about y
    send_matrix(diag_matrix(-ONE_FX, -ONE_FX, ONE_FX));     // about z
    send_matrix(diag_matrix(0, 0, 0));                      // tie, zero trace
    send_matrix(diag_matrix(-ONE_FX, -ONE_FX, -ONE_FX));    // tie, negative trace
    send_matrix(diag_matrix(5, 5, -10));                    // x/y tie
    send_matrix(diag_matrix(-9, 3, 3));                     // y/z tie
    send_matrix('0);
    send_matrix('1);
    r = {9{32'h8000_0000}};  send_matrix(r);
    r = {9{32'h7fff_ffff}};  send_matrix(r);
    r = {9{32'h5555_5555}};  send_matrix(r);
    r = {9{32'haaaa_aaaa}};  send_matrix(r);
    r = diag_matrix(0, 0, 0);
    r.m01 = 32'(-ONE_FX); r.m10 = 32'(ONE_FX); r.m22 = 32'(ONE_FX);  // quarter turn about z
    send_matrix(r);
    for (int i = 0; i < 8; i++) send_matrix(rotation_from_angles());
  endtask

  task automatic test_random(int count);
    req_t r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3, 0) != 0) begin
        r = rotation_from_angles();
      end else begin
        r.m00 = rand_entry(); r.m01 = rand_entry(); r.m02 = rand_entry();
        r.m10 = rand_entry(); r.m11 = rand_entry(); r.m12 = rand_entry();
        r.m20 = rand_entry(); r.m21 = rand_entry(); r.m22 = rand_entry();
      end
      send_matrix(r);
    end
  endtask

  // Stall the output for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_off_cycles <= 300;
    test_random(150);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    send_idle_pct = 20; recv_idle_pct = 79;
    test_random(600);
    send_idle_pct = 79; recv_idle_pct = 20;
    test_random(500);
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(650);
    test_backpressure();
    $display("Checked %0d quaternions from %0d matrices, %0d flagged as degenerate.",
             checked_count, sent_count, bad_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- rotation_matrix_to_quaternion.f -----
rtl/core/rmq_pkg.sv
rtl/core/rmq_front.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion.sv
tb/testbench.sv
